// File: hdl/mla_pkg.sv
// mla_pkg: shared types, register indexes and the letter table of the
// morse letter annunciator; no dependencies
package mla_pkg;

  localparam int unsigned CntW    = 20;
  localparam int unsigned CycW    = 16;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DAH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAP  = 2'd3;

  // ascii codes of the known letters
  localparam logic [7:0] CH_C = 8'h63;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_I = 8'h69;
  localparam logic [7:0] CH_K = 8'h6b;
  localparam logic [7:0] CH_L = 8'h6c;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_W = 8'h77;
  localparam logic [7:0] CH_X = 8'h78;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TONE = 2'd1,
    PH_GAP  = 2'd2
  } mla_phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] letter;
  } mla_in_t;

  typedef struct packed {
    logic led_on;
    logic piezo_out;
    logic busy_res;
    logic done_res;
  } mla_out_t;

  typedef struct packed {
    logic [1:0]      annunciate_mode;
    logic [CycW-1:0] dit_cycles;
    logic [CycW-1:0] dah_cycles;
    logic [CntW-1:0] gap_ticks;
  } mla_cfg_t;

  typedef struct packed {
    logic       known;
    logic [3:0] bits;
    logic [2:0] len;
  } mla_pattern_t;

  // bit i of bits is element i, 1 = dah
  function automatic mla_pattern_t letter_pattern(input logic [7:0] ch);
    mla_pattern_t p;
    p = '{known: 1'b1, bits: 4'h0, len: 3'd0};
    case (ch)
      CH_C:    begin p.bits = 4'h5; p.len = 3'd4; end
      CH_E:    begin p.bits = 4'h0; p.len = 3'd1; end
      CH_G:    begin p.bits = 4'h3; p.len = 3'd3; end
      CH_I:    begin p.bits = 4'h0; p.len = 3'd2; end
      CH_K:    begin p.bits = 4'h5; p.len = 3'd3; end
      CH_L:    begin p.bits = 4'h2; p.len = 3'd4; end
      CH_T:    begin p.bits = 4'h1; p.len = 3'd1; end
      CH_W:    begin p.bits = 4'h6; p.len = 3'd3; end
      CH_X:    begin p.bits = 4'h9; p.len = 3'd4; end
      default: p.known = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// File: hdl/mla_cfg_regs.sv
// mla_cfg_regs: configuration registers of the morse letter annunciator
// depends on mla_pkg
module mla_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mla_pkg::CfgDataW-1:0]  cfg_data_i,
  output mla_pkg::mla_cfg_t             cfg_o
);

  mla_pkg::mla_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        mla_pkg::CFG_MODE: cfg_d.annunciate_mode = cfg_data_i[1:0];
        mla_pkg::CFG_DIT:  cfg_d.dit_cycles = cfg_data_i[mla_pkg::CycW-1:0];
        mla_pkg::CFG_DAH:  cfg_d.dah_cycles = cfg_data_i[mla_pkg::CycW-1:0];
        mla_pkg::CFG_GAP:  cfg_d.gap_ticks = cfg_data_i[mla_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.annunciate_mode <= 2'd3;
      cfg_q.dit_cycles      <= 16'd50;
      cfg_q.dah_cycles      <= 16'd150;
      cfg_q.gap_ticks       <= 20'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/mla_core.sv
// mla_core: letter sequencer state and the one-item update step
// depends on mla_pkg
module mla_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mla_pkg::mla_in_t   item_i,
  input  mla_pkg::mla_cfg_t  cfg_i,
  output mla_pkg::mla_out_t  res_o
);

  mla_pkg::mla_phase_e         phase_q, phase_d;
  logic [3:0]                  bits_q, bits_d;
  logic [2:0]                  len_q, len_d;
  logic [2:0]                  idx_q, idx_d;
  logic [mla_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                        piezo_q, piezo_d;
  logic                        done;
  logic                        busy;
  logic [mla_pkg::CntW-1:0]    cnt_dec;
  logic [2:0]                  idx_inc;
  mla_pkg::mla_pattern_t       pat;

  // tone length in ticks: twice the cycle count, zero counts as one
  function automatic logic [mla_pkg::CntW-1:0] tone_ticks(
    input logic [3:0]        bits,
    input logic [1:0]        idx,
    input mla_pkg::mla_cfg_t cfg
  );
    logic [mla_pkg::CycW-1:0] cyc;
    cyc = bits[idx] ? cfg.dah_cycles : cfg.dit_cycles;
    if (cyc == '0) begin
      cyc = mla_pkg::CycW'(1);
    end
    return mla_pkg::CntW'({cyc, 1'b0});
  endfunction

  assign busy    = (phase_q == mla_pkg::PH_TONE) || (phase_q == mla_pkg::PH_GAP);
  assign cnt_dec = cnt_q - mla_pkg::CntW'(1);
  assign idx_inc = idx_q + 3'd1;
  assign pat     = mla_pkg::letter_pattern(item_i.letter);

  // next state
  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    len_d   = len_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    piezo_d = piezo_q;
    done    = 1'b0;
    if (item_i.command == mla_pkg::CMD_START) begin
      if (!busy) begin
        if (pat.known) begin
          bits_d  = pat.bits;
          len_d   = pat.len;
          idx_d   = 3'd0;
          cnt_d   = tone_ticks(pat.bits, 2'd0, cfg_i);
          piezo_d = 1'b1;
          phase_d = mla_pkg::PH_TONE;
        end else begin
          phase_d = mla_pkg::PH_IDLE;
          piezo_d = 1'b0;
          done    = 1'b1;
        end
      end
    end else begin
      unique case (phase_q)
        mla_pkg::PH_TONE: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            piezo_d = 1'b0;
            idx_d   = idx_inc;
            if (idx_inc >= len_q) begin
              phase_d = mla_pkg::PH_IDLE;
              done    = 1'b1;
            end else if (cfg_i.gap_ticks == '0) begin
              cnt_d   = tone_ticks(bits_q, idx_inc[1:0], cfg_i);
              piezo_d = 1'b1;
              phase_d = mla_pkg::PH_TONE;
            end else begin
              cnt_d   = cfg_i.gap_ticks;
              phase_d = mla_pkg::PH_GAP;
            end
          end else begin
            piezo_d = ~piezo_q;
          end
        end
        mla_pkg::PH_GAP: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            cnt_d   = tone_ticks(bits_q, idx_q[1:0], cfg_i);
            piezo_d = 1'b1;
            phase_d = mla_pkg::PH_TONE;
          end
        end
        default: phase_d = mla_pkg::PH_IDLE;
      endcase
    end
  end

  // result of this item, from the updated state
  always_comb begin
    res_o.led_on    = (phase_d == mla_pkg::PH_TONE) && cfg_i.annunciate_mode[0];
    res_o.piezo_out = (phase_d == mla_pkg::PH_TONE) && cfg_i.annunciate_mode[1]
                      && piezo_d;
    res_o.busy_res  = (phase_d == mla_pkg::PH_TONE) || (phase_d == mla_pkg::PH_GAP);
    res_o.done_res  = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mla_pkg::PH_IDLE;
      bits_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      piezo_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      piezo_q <= piezo_d;
    end
  end

endmodule

// File: hdl/morse_letter_annunciator_top.sv
// morse_letter_annunciator_top: input register, sequencer core and result
// register; depends on mla_pkg, mla_cfg_regs and mla_core
//
//   channel   direction  handshake                     payload
//   in        in         in_valid_i / in_stall_o       in_data_i  (mla_in_t)
//   out       out        out_valid_o / out_stall_i     out_data_o (mla_out_t)
//   cfg       in         cfg_we_i                      cfg_index_i, cfg_data_i
//
// one word a cycle sustained while the output is not stalled; each word goes
// through the input register and then through the core into the result register
// reset clears the valid flags, the sequencer state and loads register defaults
// a stall on the output holds the result register and the input register,
// which then stalls the input side
module morse_letter_annunciator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mla_pkg::mla_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mla_pkg::mla_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [mla_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mla_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic               in_valid_q;
  mla_pkg::mla_in_t   in_data_q;
  logic               out_valid_q;
  mla_pkg::mla_out_t  out_data_q;
  logic               advance;
  mla_pkg::mla_cfg_t  cfg;
  mla_pkg::mla_out_t  res;

  // a word moves through the core when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  mla_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // state is committed only on the cycle the word moves on
  mla_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: tb/sv/morse_letter_annunciator_top_test.sv
// morse_letter_annunciator_top_test: self-checking bench for the morse letter
// annunciator, with its own keyer model, a queued driver and a checking monitor
// depends on mla_pkg and morse_letter_annunciator_top
module morse_letter_annunciator_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  // run limits and pacing
  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 6;
  localparam int HoldAt      = 300;
  localparam int HoldLen     = 60;

  // bit positions inside the mode register
  localparam int LedBit   = 0;
  localparam int PiezoBit = 1;

  // one letter of the table: element i is a dah when dahs[i] is set
  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [3:0] dahs;
  } glyph_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  mla_pkg::mla_in_t             in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  mla_pkg::mla_out_t            out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [mla_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mla_pkg::CfgDataW-1:0] cfg_data_i = '0;

  morse_letter_annunciator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // keyer model: register copy and sequencer state, reset values
  // ---------------------------------------------------------------------------
  logic [1:0]           k_mode  = 2'd3;
  logic [15:0]          k_dit   = 16'd50;
  logic [15:0]          k_dah   = 16'd150;
  logic [19:0]          k_gap   = 20'd500;
  logic [3:0]           k_dahs  = '0;
  logic [2:0]           k_len   = '0;
  logic [2:0]           k_idx   = '0;
  mla_pkg::mla_phase_e  k_phase = mla_pkg::PH_IDLE;
  logic [19:0]          k_count = '0;
  logic                 k_piezo = 1'b0;

  // queues: words still to send, levels expected back
  mla_pkg::mla_in_t  pending_words[$];
  mla_pkg::mla_out_t levels_due[$];

  // bookkeeping
  int  fail_count    = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  letters_done  = 0;
  int  settings_used = 0;
  int  gen_left      = 0;   // ticks the generator still owes the current letter
  int  cycle_count   = 0;
  bit  calm          = 1'b0; // no idling on either side once set

  logic [7:0] known_letters[9] = '{mla_pkg::CH_C, mla_pkg::CH_E, mla_pkg::CH_G,
                                   mla_pkg::CH_I, mla_pkg::CH_K, mla_pkg::CH_L,
                                   mla_pkg::CH_T, mla_pkg::CH_W, mla_pkg::CH_X};

  // morse table, first element in bit 0
  function automatic glyph_t glyph_of(input logic [7:0] ch);
    glyph_t g;
    case (ch)
      mla_pkg::CH_C: g = '{1'b1, 3'd4, 4'b0101};  // dah dit dah dit
      mla_pkg::CH_E: g = '{1'b1, 3'd1, 4'b0000};  // dit
      mla_pkg::CH_G: g = '{1'b1, 3'd3, 4'b0011};  // dah dah dit
      mla_pkg::CH_I: g = '{1'b1, 3'd2, 4'b0000};  // dit dit
      mla_pkg::CH_K: g = '{1'b1, 3'd3, 4'b0101};  // dah dit dah
      mla_pkg::CH_L: g = '{1'b1, 3'd4, 4'b0010};  // dit dah dit dit
      mla_pkg::CH_T: g = '{1'b1, 3'd1, 4'b0001};  // dah
      mla_pkg::CH_W: g = '{1'b1, 3'd3, 4'b0110};  // dit dah dah
      mla_pkg::CH_X: g = '{1'b1, 3'd4, 4'b1001};  // dah dit dit dah
      default:       g = '{1'b0, 3'd0, 4'b0000};
    endcase
    return g;
  endfunction

  // load the tone of the current element; a zero length counts as one cycle
  function automatic void load_tone();
    logic [15:0] cyc;
    cyc = k_dahs[k_idx[1:0]] ? k_dah : k_dit;
    if (cyc == 16'd0) cyc = 16'd1;
    k_count = {3'b000, cyc, 1'b0};  // two ticks per tone cycle
    k_piezo = 1'b1;
    k_phase = mla_pkg::PH_TONE;
  endfunction

  // advance the keyer by one word and give the levels it shows afterwards
  task automatic step_keyer(input mla_pkg::mla_in_t w, output mla_pkg::mla_out_t lv);
    glyph_t g;
    logic   finished;
    logic   busy;
    finished = 1'b0;
    busy = (k_phase == mla_pkg::PH_TONE) || (k_phase == mla_pkg::PH_GAP);
    if (w.command == mla_pkg::CMD_START) begin
      // a start while a letter is under way changes nothing
      if (!busy) begin
        g = glyph_of(w.letter);
        if (g.known) begin
          k_dahs = g.dahs;
          k_len  = g.len;
          k_idx  = '0;
          load_tone();
        end else begin
          // unknown letter finishes on the spot
          k_phase  = mla_pkg::PH_IDLE;
          k_piezo  = 1'b0;
          finished = 1'b1;
        end
      end
    end else if (k_phase == mla_pkg::PH_TONE) begin
      k_count = k_count - 20'd1;
      if (k_count == '0) begin
        k_piezo = 1'b0;
        k_idx   = k_idx + 3'd1;
        if (k_idx >= k_len) begin
          k_phase  = mla_pkg::PH_IDLE;
          finished = 1'b1;
        end else if (k_gap == '0) begin
          load_tone();              // no gap: next tone right away
        end else begin
          k_count = k_gap;
          k_phase = mla_pkg::PH_GAP;
        end
      end else begin
        k_piezo = ~k_piezo;
      end
    end else if (k_phase == mla_pkg::PH_GAP) begin
      k_count = k_count - 20'd1;
      if (k_count == '0) load_tone();
    end else begin
      k_phase = mla_pkg::PH_IDLE;   // tick while idle
    end
    lv.led_on    = (k_phase == mla_pkg::PH_TONE) && k_mode[LedBit];
    lv.piezo_out = (k_phase == mla_pkg::PH_TONE) && k_mode[PiezoBit] && k_piezo;
    lv.busy_res  = (k_phase == mla_pkg::PH_TONE) || (k_phase == mla_pkg::PH_GAP);
    lv.done_res  = finished;
  endtask

  // ---------------------------------------------------------------------------
  // driver: sends pending words, predicts each accepted one
  // ---------------------------------------------------------------------------
  int                send_gap = 0;
  mla_pkg::mla_out_t predicted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        step_keyer(in_data_i, predicted);
        levels_due.push_back(predicted);
        words_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled word stays on the bus
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        // idle burst, its length drawn at random
        send_gap = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_words.pop_front();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall: short random bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  int stall_left  = 0;
  int hold_left   = 0;
  int words_taken = 0;
  bit held        = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) words_taken++;
      // long hold so the pipeline fills and backs up into the input
      if (words_taken == HoldAt && !held) begin
        hold_left = HoldLen;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void compare_level(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      fail_count++;
    end
  endfunction

  mla_pkg::mla_out_t want_levels;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (levels_due.size() == 0) begin
        $error("result %b arrived with no word outstanding", out_data_o);
        fail_count++;
      end else begin
        want_levels = levels_due.pop_front();
        compare_level("led_on", want_levels.led_on, out_data_o.led_on);
        compare_level("piezo_out", want_levels.piezo_out, out_data_o.piezo_out);
        compare_level("busy_res", want_levels.busy_res, out_data_o.busy_res);
        compare_level("done_res", want_levels.done_res, out_data_o.done_res);
        if (want_levels.done_res) letters_done++;
        words_checked++;
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               levels_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // queue one word and track how many ticks the letter it starts will need
  task automatic add_word(input logic cmd, input logic [7:0] ch);
    glyph_t g;
    int     i;
    logic [15:0] cyc;
    pending_words.push_back(mla_pkg::mla_in_t'{command: cmd, letter: ch});
    if (cmd == mla_pkg::CMD_START) begin
      g = glyph_of(ch);
      if (gen_left == 0 && g.known) begin
        // each tone takes two ticks a cycle, each inner gap its tick count
        for (i = 0; i < g.len; i++) begin
          cyc = g.dahs[i] ? k_dah : k_dit;
          if (cyc == 16'd0) cyc = 16'd1;
          gen_left += 2 * int'(cyc);
          if (i < g.len - 1) gen_left += int'(k_gap);
        end
      end
    end else if (gen_left > 0) begin
      gen_left--;
    end
  endtask

  task automatic write_reg(input logic [mla_pkg::CfgIdxW-1:0] idx,
                           input logic [mla_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      mla_pkg::CFG_MODE: k_mode = val[1:0];
      mla_pkg::CFG_DIT:  k_dit  = val[15:0];
      mla_pkg::CFG_DAH:  k_dah  = val[15:0];
      mla_pkg::CFG_GAP:  k_gap  = val[19:0];
      default:  ;
    endcase
  endtask

  // new register setting; only called with the block drained
  task automatic configure(input logic [1:0] mode, input logic [15:0] dit,
                           input logic [15:0] dah, input logic [19:0] gap);
    write_reg(mla_pkg::CFG_MODE, mla_pkg::CfgDataW'(mode));
    write_reg(mla_pkg::CFG_DIT, mla_pkg::CfgDataW'(dit));
    write_reg(mla_pkg::CFG_DAH, mla_pkg::CfgDataW'(dah));
    write_reg(mla_pkg::CFG_GAP, gap);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  // finish the letter in progress, then wait until every result is back
  task automatic settle();
    while (gen_left > 0) add_word(mla_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    while (pending_words.size() != 0 || levels_due.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly whole letters with random content, some noise and cut-off letters
  task automatic random_letters(input int n_words);
    int         made;
    int         cut;
    int         r;
    int         j;
    logic [7:0] b;
    glyph_t     g;
    made = 0;
    while (made < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // unknown letter
        do begin
          b = 8'($urandom_range(0, 255));
          g = glyph_of(b);
        end while (g.known);
        add_word(mla_pkg::CMD_START, b);
        made++;
      end else if (r < 14) begin
        add_word(mla_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        made++;
      end else begin
        add_word(mla_pkg::CMD_START, known_letters[$urandom_range(0, 8)]);
        made++;
        cut = gen_left;
        // now and then cut the letter short so the next start lands while busy
        if ($urandom_range(0, 11) == 0) cut = $urandom_range(0, gen_left);
        for (j = 0; j < cut; j++) begin
          if ($urandom_range(0, 19) == 0)
            add_word(mla_pkg::CMD_START, 8'($urandom_range(0, 255)));
          add_word(mla_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
          made++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: one dit letter at the power-on lengths
    add_word(mla_pkg::CMD_START, mla_pkg::CH_E);
    settle();

    // zero lengths count as one cycle, zero gap chains tones back to back
    configure(2'd3, 16'd0, 16'd0, 20'd0);
    add_word(mla_pkg::CMD_TICK, 8'h00);        // ticks while idle
    add_word(mla_pkg::CMD_TICK, 8'hff);
    add_word(mla_pkg::CMD_START, 8'h00);       // unknown letters end at once
    add_word(mla_pkg::CMD_START, 8'hff);
    add_word(mla_pkg::CMD_START, 8'h43);       // upper case is not in the table
    add_word(mla_pkg::CMD_START, mla_pkg::CH_K);
    add_word(mla_pkg::CMD_TICK, 8'h5a);
    add_word(mla_pkg::CMD_TICK, 8'ha5);
    add_word(mla_pkg::CMD_START, mla_pkg::CH_E); // start while busy is ignored
    add_word(mla_pkg::CMD_START, 8'h00);
    settle();

    // both outputs disabled, short gap between elements
    configure(2'd0, 16'd1, 16'd2, 20'd1);
    add_word(mla_pkg::CMD_START, mla_pkg::CH_X);
    settle();

    // random phases with small lengths, larger ones in one pass, the mode cycling through all values
    for (p = 0; p < 8; p++) begin
      if (p == 6)
        configure(2'(p % 4), 16'($urandom_range(5, 20)), 16'($urandom_range(10, 40)),
                  20'($urandom_range(10, 30)));
      else
        configure(2'(p % 4), 16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                  20'($urandom_range(0, 5)));
      random_letters(65);
      settle();
    end

    // widest gap setting; single-element letters, so the huge gap is never loaded or run
    configure(2'd2, 16'd8, 16'd12, 20'hfffff);
    add_word(mla_pkg::CMD_START, mla_pkg::CH_E);
    settle();
    add_word(mla_pkg::CMD_START, mla_pkg::CH_T);
    settle();

    // last stretch at full rate, no idling on either side
    calm = 1'b1;
    configure(2'd1, 16'd2, 16'd3, 20'd0);
    random_letters(60);
    settle();

    $display("covered %0d input words and %0d checked results over %0d register settings",
             words_sent, words_checked, settings_used);
    $display("%0d letters finished, one output hold of %0d cycles", letters_done, HoldLen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
